// File: rtl/core/irclt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irclt_pkg: shared types and constants of the IRC line framer
// Byte codes, token phases, result item layout and queue sizing.
// ----------------------------------------------------------------------------
package irclt_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int         LEN_W          = 10;
	localparam logic [LEN_W-1:0] LINE_LEN_RESET = 10'd510;

	// default depth of the front-to-back request queue
	localparam int         IRCLT_QDEPTH   = 4;

	typedef enum logic [2:0] {
		PH_START    = 3'd0,
		PH_PREFIX   = 3'd1,
		PH_COMMAND  = 3'd2,
		PH_PARAMS   = 3'd3,
		PH_TRAILING = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PREFIX   = 2'd0,
		KIND_COMMAND  = 2'd1,
		KIND_PARAM    = 2'd2,
		KIND_TRAILING = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		kind_t      token_kind;
		logic       token_first;
		logic       line_end;
		logic       truncated;
	} item_t;

	// up to two result items produced by one accepted byte
	typedef struct packed {
		logic [1:0] n;
		item_t      item0;
		item_t      item1;
	} push_t;

	typedef struct packed {
		logic [LEN_W-1:0] count;
		phase_t           phase;
		logic             ats;
	} line_state_t;

	localparam line_state_t LINE_RESET = '{count: '0, phase: PH_START, ats: 1'b1};

	localparam item_t LINE_END_ITEM = '{data_byte: 8'd0, token_kind: KIND_PREFIX,
		token_first: 1'b0, line_end: 1'b1, truncated: 1'b0};

	localparam item_t TRUNC_END_ITEM = '{data_byte: 8'd0, token_kind: KIND_PREFIX,
		token_first: 1'b0, line_end: 1'b1, truncated: 1'b1};

endpackage

// File: rtl/core/irc_line_framer_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_framer_tokenizer_unit: IRC line framer and tokenizer
// Frames CR LF lines from a byte stream and tags content bytes by token.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid/tready          tdata = rx_byte
// m_axis    out        tvalid/tready          tdata = data_byte, tlast = line_end,
//                                             tuser = kind, first, truncated
// cfg       in         cfg_we (no wait)       cfg_wdata = max_line_len
//
// Flow: one received byte per cycle while s_axis_tready is high; a result
//   item reaches m_axis through the queue write, then the output register,
//   once that register is free. A byte gives zero, one or two items.
// Stalls: s_axis_tready drops while fewer than two queue slots are free, so
//   a back-pressured master side fills the queue before the slave side stops.
// Reset: arst_n clears line state, queue pointers and the output valid;
//   max_line_len returns to 510.
//
module irc_line_framer_tokenizer_unit #(
	parameter int QUEUE_DEPTH = irclt_pkg::IRCLT_QDEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [irclt_pkg::LEN_W-1:0]  cfg_wdata,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [7:0]                   m_axis_tdata,   // [7:0] data_byte
	output logic                         m_axis_tlast,   // line_end
	output logic [3:0]                   m_axis_tuser    // [1:0] token_kind,
	                                                     // [2] token_first,
	                                                     // [3] truncated
);
	import irclt_pkg::*;

	logic  in_accept;
	push_t push;
	logic  q_room;
	logic  q_pop;
	logic  q_nonempty;
	item_t q_head;
	item_t out_item;

	// accept a byte whenever the queue can absorb the worst case of two items
	assign s_axis_tready = q_room;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// front: classify the byte and advance the line and token state
	irclt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (in_accept),
		.rx_byte   (s_axis_tdata),
		.push      (push)
	);

	// queue: decouple the classifier from the output handshake
	irclt_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (q_room),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	// back: hold the current result until the master side takes it
	irclt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_item   (out_item)
	);

	// unpack the result item onto the stream fields
	assign m_axis_tdata = out_item.data_byte;
	assign m_axis_tlast = out_item.line_end;
	assign m_axis_tuser = {out_item.truncated, out_item.token_first, out_item.token_kind};

endmodule

// File: rtl/core/irclt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irclt_front: byte classifier
// Frames lines, tracks token phase and turns each byte into zero to two items.
// ----------------------------------------------------------------------------
module irclt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [irclt_pkg::LEN_W-1:0]  cfg_wdata,
	input  logic                         accept,
	input  logic [7:0]                   rx_byte,
	output irclt_pkg::push_t             push
);
	import irclt_pkg::*;

	typedef struct packed {
		line_state_t st;
		logic        vld;
		logic        ovf;
		item_t       item;
	} cb_t;

	typedef struct packed {
		line_state_t st;
		logic        cr;
		logic        disc;
		push_t       push;
	} step_t;

	line_state_t      ls_q;
	logic             cr_q;
	logic             disc_q;
	logic [LEN_W-1:0] max_len_q;
	step_t            step;

	// one content byte against the current line state
	function automatic cb_t content_byte(line_state_t st, logic [7:0] c,
			logic [LEN_W-1:0] maxl);
		cb_t r;
		r      = '0;
		r.st   = st;
		if (st.count >= maxl) begin
			r.vld  = 1'b1;
			r.ovf  = 1'b1;
			r.item = TRUNC_END_ITEM;
			r.st   = LINE_RESET;
		end else begin
			r.st.count = st.count + LEN_W'(1);
			if (st.phase == PH_TRAILING) begin
				r.vld                 = 1'b1;
				r.item.data_byte      = c;
				r.item.token_kind     = KIND_TRAILING;
				r.item.token_first    = st.ats;
				r.st.ats              = 1'b0;
			end else if (c == CH_SPACE) begin
				unique case (st.phase)
					PH_PREFIX: begin
						r.st.phase = PH_COMMAND;
						r.st.ats   = 1'b1;
					end
					PH_COMMAND: begin
						if (!st.ats) begin
							r.st.phase = PH_PARAMS;
							r.st.ats   = 1'b1;
						end
					end
					PH_PARAMS: begin
						r.st.ats = 1'b1;
					end
					default: begin
					end
				endcase
			end else begin
				r.vld            = 1'b1;
				r.item.data_byte = c;
				r.st.ats         = 1'b0;
				unique case (st.phase)
					PH_PREFIX: begin
						r.item.token_kind  = KIND_PREFIX;
						r.item.token_first = 1'b0;
					end
					PH_COMMAND: begin
						r.item.token_kind  = KIND_COMMAND;
						r.item.token_first = st.ats;
					end
					PH_PARAMS: begin
						r.item.token_first = st.ats;
						if (st.ats && c == CH_COLON) begin
							r.st.phase        = PH_TRAILING;
							r.item.token_kind = KIND_TRAILING;
						end else begin
							r.item.token_kind = KIND_PARAM;
						end
					end
					default: begin
						r.item.token_first = 1'b1;
						if (c == CH_COLON) begin
							r.st.phase        = PH_PREFIX;
							r.item.token_kind = KIND_PREFIX;
						end else begin
							r.st.phase        = PH_COMMAND;
							r.item.token_kind = KIND_COMMAND;
						end
					end
				endcase
			end
		end
		return r;
	endfunction

	// full per-byte transition: discard, pending CR, then the byte itself
	function automatic step_t do_step(line_state_t st, logic cr, logic disc,
			logic [7:0] b, logic [LEN_W-1:0] maxl);
		step_t s;
		cb_t   r0;
		cb_t   r1;
		logic  go;
		s      = '0;
		s.st   = st;
		s.cr   = cr;
		s.disc = disc;
		r0     = '0;
		r1     = '0;
		go     = 1'b0;
		if (disc) begin
			if (cr && b == CH_LF) begin
				s.cr   = 1'b0;
				s.disc = 1'b0;
				s.st   = LINE_RESET;
			end else begin
				s.cr = (b == CH_CR);
			end
		end else begin
			go = 1'b1;
			if (cr) begin
				s.cr = 1'b0;
				if (b == CH_LF) begin
					s.push.n     = 2'd1;
					s.push.item0 = LINE_END_ITEM;
					s.st         = LINE_RESET;
					go           = 1'b0;
				end else begin
					r0   = content_byte(st, CH_CR, maxl);
					s.st = r0.st;
					if (r0.vld) begin
						s.push.n     = 2'd1;
						s.push.item0 = r0.item;
					end
					if (r0.ovf) begin
						s.disc = 1'b1;
						s.cr   = (b == CH_CR);
						go     = 1'b0;
					end
				end
			end
			if (go) begin
				if (b == CH_CR) begin
					s.cr = 1'b1;
				end else begin
					r1   = content_byte(s.st, b, maxl);
					s.st = r1.st;
					if (r1.vld) begin
						if (s.push.n == 2'd0) begin
							s.push.item0 = r1.item;
						end else begin
							s.push.item1 = r1.item;
						end
						s.push.n = s.push.n + 2'd1;
					end
					if (r1.ovf) begin
						s.disc = 1'b1;
						s.cr   = 1'b0;
					end
				end
			end
		end
		return s;
	endfunction

	always_comb begin
		step = do_step(ls_q, cr_q, disc_q, rx_byte, max_len_q);
	end

	// outputs: items go to the queue only for an accepted byte
	always_comb begin
		push = step.push;
		if (!accept) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q   <= LINE_RESET;
			cr_q   <= 1'b0;
			disc_q <= 1'b0;
		end else if (accept) begin
			ls_q   <= step.st;
			cr_q   <= step.cr;
			disc_q <= step.disc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LINE_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

endmodule

// File: rtl/core/irclt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irclt_queue: request queue between front and back
// Takes up to two items per cycle, gives one per cycle while pop is high.
// ----------------------------------------------------------------------------
module irclt_queue #(
	parameter int QUEUE_DEPTH = irclt_pkg::IRCLT_QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  irclt_pkg::push_t  push,
	output logic              room,
	input  logic              pop,
	output logic              nonempty,
	output irclt_pkg::item_t  head
);
	import irclt_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t           mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   wp1;
	logic [AW-1:0]   wp2;

	function automatic logic [AW-1:0] nxt(logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign wp1      = nxt(wp_q);
	assign wp2      = nxt(wp1);
	assign room     = (cnt_q <= CW'(QUEUE_DEPTH - 2));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.item0;
		end
		if (push.n == 2'd2) begin
			mem_q[wp1] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (push.n)
				2'd1:    wp_q <= wp1;
				2'd2:    wp_q <= wp2;
				default: wp_q <= wp_q;
			endcase
			if (pop) begin
				rp_q <= nxt(rp_q);
			end
			cnt_q <= cnt_q + CW'(push.n) - CW'(pop);
		end
	end

endmodule

// File: rtl/core/irclt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irclt_back: output stage
// Holds one result item in a register toward the master side.
// ----------------------------------------------------------------------------
module irclt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nonempty,
	input  irclt_pkg::item_t  q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output irclt_pkg::item_t  out_item
);
	import irclt_pkg::*;

	logic  vld_q;
	item_t item_q;
	logic  load;

	assign load      = !vld_q || out_ready;
	assign q_pop     = q_nonempty && load;
	assign out_valid = vld_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= q_nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_head;
		end
	end

endmodule

// File: tb/sv/irc_line_framer_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_framer_tokenizer_unit_tb: self-checking bench for the IRC framer
// Streams received bytes into the unit: a directed set first, then random IRC
// lines and noise. A built-in line parser predicts every tagged token byte and
// every line-end request. The monitor checks each result against the oldest
// prediction. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module irc_line_framer_tokenizer_unit_tb;
	import irclt_pkg::*;

	// receiver back-pressure patterns
	typedef enum logic [1:0] {
		RX_FREE    = 2'd0,
		RX_RANDOM  = 2'd1,
		RX_SPARSE  = 2'd2,
		RX_BURSTY  = 2'd3
	} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [LEN_W-1:0]     cfg_wdata = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = 8'd0;    // [7:0] rx_byte
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;           // [7:0] data_byte
	logic                 m_axis_tlast;           // line_end
	logic [3:0]           m_axis_tuser;           // [1:0] token_kind, [2] token_first,
	                                              // [3] truncated

	irc_line_framer_tokenizer_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Line parser: mirrors the framer state and predicts its results
	// ------------------------------------------------------------------
	logic [LEN_W-1:0] line_limit = LINE_LEN_RESET;
	logic [LEN_W-1:0] line_count = '0;
	logic             cr_held = 1'b0;       // CR seen, waiting to see if LF follows
	logic             skipping_line = 1'b0; // dropping the tail of an overlong line
	phase_t           parse_phase = PH_START;
	logic             token_open = 1'b1;    // next non-space byte opens a token

	item_t            expected_items[$];
	logic [7:0]       pending_bytes[$];

	int               error_count = 0;
	int               bytes_queued = 0;
	int               bytes_offered = 0;
	int               bytes_taken = 0;

	task automatic restart_line();
		line_count = '0;
		parse_phase = PH_START;
		token_open = 1'b1;
	endtask

	// Append one predicted result at the tail of the expectation queue.
	task automatic expect_item(input item_t it);
		expected_items.insert(expected_items.size(), it);
	endtask

	// Discard mode: only CR LF ends it.
	task automatic drop_byte(input logic [7:0] b);
		if (cr_held && b == CH_LF) begin
			cr_held = 1'b0;
			skipping_line = 1'b0;
			restart_line();
		end else begin
			cr_held = (b == CH_CR);
		end
	endtask

	// Count, tag and queue one content byte, or close the line on overflow.
	task automatic tag_content(input logic [7:0] c);
		item_t  it;
		kind_t  k;
		logic   f;
		if (line_count >= line_limit) begin
			expect_item(TRUNC_END_ITEM);
			restart_line();
			skipping_line = 1'b1;
			cr_held = 1'b0;
			return;
		end
		line_count = line_count + 1'b1;

		// trailing token takes everything, spaces included
		if (parse_phase == PH_TRAILING) begin
			it = '{data_byte: c, token_kind: KIND_TRAILING, token_first: token_open,
				line_end: 1'b0, truncated: 1'b0};
			expect_item(it);
			token_open = 1'b0;
			return;
		end

		// spaces delimit tokens and are never sent
		if (c == CH_SPACE) begin
			case (parse_phase)
				PH_PREFIX: begin
					parse_phase = PH_COMMAND;
					token_open = 1'b1;
				end
				PH_COMMAND: begin
					if (!token_open) begin
						parse_phase = PH_PARAMS;
						token_open = 1'b1;
					end
				end
				PH_PARAMS: token_open = 1'b1;
				default: ;
			endcase
			return;
		end

		case (parse_phase)
			PH_START: begin
				if (c == CH_COLON) begin
					parse_phase = PH_PREFIX;
					k = KIND_PREFIX;
				end else begin
					parse_phase = PH_COMMAND;
					k = KIND_COMMAND;
				end
				f = 1'b1;
			end
			PH_PREFIX: begin
				k = KIND_PREFIX;
				f = 1'b0;
			end
			PH_COMMAND: begin
				k = KIND_COMMAND;
				f = token_open;
			end
			default: begin
				// a parameter opening with a colon becomes the trailing token
				f = token_open;
				if (token_open && c == CH_COLON) begin
					parse_phase = PH_TRAILING;
					k = KIND_TRAILING;
				end else begin
					k = KIND_PARAM;
				end
			end
		endcase
		token_open = 1'b0;
		it = '{data_byte: c, token_kind: k, token_first: f, line_end: 1'b0,
			truncated: 1'b0};
		expect_item(it);
	endtask

	// Advance the parser by one accepted request.
	task automatic frame_byte(input logic [7:0] b);
		if (skipping_line) begin
			drop_byte(b);
			return;
		end
		if (cr_held) begin
			cr_held = 1'b0;
			if (b == CH_LF) begin
				expect_item(LINE_END_ITEM);
				restart_line();
				return;
			end
			// lone CR: it was content after all
			tag_content(CH_CR);
			if (skipping_line) begin
				drop_byte(b);
				return;
			end
		end
		if (b == CH_CR) begin
			cr_held = 1'b1;
			return;
		end
		tag_content(b);
	endtask

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 20)
			$display("ERROR %0t ns: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of requests from the pending queue, random gaps
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || bytes_taken == bytes_offered) begin
			// previous request gone (or none): insert gap or advance
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				s_axis_tdata <= pending_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				bytes_offered++;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern is redrawn at random when its run ends
	rx_mode_t rx_mode = RX_FREE;
	int       mode_left = 0;
	int       hold_left = 0;
	logic     hold_ready = 1'b1;
	int       cycle_count = 0;

	always @(negedge clk) begin
		cycle_count++;
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 200);
		end
		mode_left--;
		case (rx_mode)
			RX_FREE:   m_axis_tready <= 1'b1;
			RX_RANDOM: m_axis_tready <= ($urandom_range(0, 9) < 7);
			RX_SPARSE: m_axis_tready <= (cycle_count % 4 == 0);
			default: begin
				if (hold_left == 0) begin
					hold_ready = !hold_ready;
					hold_left = hold_ready ? $urandom_range(1, 8) : $urandom_range(1, 20);
				end
				hold_left--;
				m_axis_tready <= hold_ready;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each accepted request, check each result
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		item_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				bytes_taken++;
				frame_byte(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_items.size() == 0) begin
					flag_error($sformatf("unexpected result data=%02h last=%b user=%h",
						m_axis_tdata, m_axis_tlast, m_axis_tuser));
				end else begin
					want = expected_items.pop_front();
					if (m_axis_tdata != want.data_byte)
						flag_error($sformatf("data_byte %02h, want %02h",
							m_axis_tdata, want.data_byte));
					if (kind_t'(m_axis_tuser[1:0]) != want.token_kind)
						flag_error($sformatf("token_kind %0d, want %0d",
							m_axis_tuser[1:0], want.token_kind));
					if (m_axis_tuser[2] != want.token_first)
						flag_error($sformatf("token_first %b, want %b",
							m_axis_tuser[2], want.token_first));
					if (m_axis_tlast != want.line_end)
						flag_error($sformatf("line_end %b, want %b",
							m_axis_tlast, want.line_end));
					if (m_axis_tuser[3] != want.truncated)
						flag_error($sformatf("truncated %b, want %b",
							m_axis_tuser[3], want.truncated));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b);
		pending_bytes.insert(pending_bytes.size(), b);
		bytes_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_crlf();
		push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic push_spaces();
		int n;
		n = $urandom_range(1, 3);
		repeat (n) push_byte(CH_SPACE);
	endtask

	// Mostly printable token characters, now and then any byte at all.
	task automatic push_word(input int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 29) == 0)
				c = 8'($urandom_range(0, 255));
			else
				c = 8'($urandom_range(8'h21, 8'h7E));
			push_byte(c);
		end
	endtask

	// One random IRC line (or a stretch of noise) with random content.
	task automatic push_line();
		int         nparams;
		int         sel;
		logic [7:0] c;
		if ($urandom_range(0, 9) == 0) begin
			// noise, biased toward the bytes that steer the parser
			repeat ($urandom_range(1, 20)) begin
				sel = $urandom_range(0, 7);
				case (sel)
					0: c = CH_CR;
					1: c = CH_LF;
					2: c = CH_SPACE;
					3: c = CH_COLON;
					default: c = 8'($urandom_range(0, 255));
				endcase
				push_byte(c);
			end
			return;
		end
		if ($urandom_range(0, 7) == 0)
			push_spaces();
		if ($urandom_range(0, 2) == 0) begin
			push_byte(CH_COLON);
			push_word($urandom_range(1, 8));
			push_spaces();
		end
		push_word($urandom_range(1, 6));
		nparams = $urandom_range(0, 4);
		repeat (nparams) begin
			push_spaces();
			push_word($urandom_range(1, 6));
		end
		if ($urandom_range(0, 1) == 0) begin
			push_spaces();
			push_byte(CH_COLON);
			repeat ($urandom_range(0, 15)) begin
				sel = $urandom_range(0, 5);
				case (sel)
					0: push_byte(CH_SPACE);
					1: push_byte(CH_COLON);
					default: push_word(1);
				endcase
			end
		end
		// terminator: mostly CR LF, sometimes a bare LF or nothing
		sel = $urandom_range(0, 15);
		if (sel == 0)
			push_byte(CH_LF);
		else if (sel != 1)
			push_crlf();
	endtask

	// Hold until nothing is queued, in flight or expected.
	task automatic wait_idle();
		while (pending_bytes.size() > 0 || s_axis_tvalid || expected_items.size() > 0)
			@(posedge clk);
		// a request that gives no result may still sit in the pipeline
		repeat (8) @(posedge clk);
	endtask

	task automatic set_line_limit(input logic [LEN_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		line_limit = v;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	logic [LEN_W-1:0] phase_limits[8];
	int               phase_start;

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: prefix, command, repeated spaces, parameter, bare trailing
		push_text(":p C  x :");
		push_crlf();
		// empty line
		push_crlf();
		// leading space, byte extremes, lone CR inside the command
		push_byte(CH_SPACE);
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_byte(8'h00);
		push_crlf();

		// overflow drops the tail; exact-length line with CR LF ends normally
		set_line_limit(10'd2);
		push_text("abc");
		push_crlf();
		push_text("ab");
		push_crlf();

		// random phases, limits from the extremes down to zero
		phase_limits[0] = 10'd1023;
		phase_limits[1] = 10'd0;
		phase_limits[2] = 10'd1;
		phase_limits[3] = LEN_W'($urandom_range(3, 40));
		phase_limits[4] = LINE_LEN_RESET;
		phase_limits[5] = LEN_W'($urandom_range(41, 200));
		phase_limits[6] = LEN_W'($urandom_range(3, 40));
		phase_limits[7] = LEN_W'($urandom_range(201, 1022));
		foreach (phase_limits[p]) begin
			set_line_limit(phase_limits[p]);
			phase_start = bytes_queued;
			while (bytes_queued - phase_start < 215)
				push_line();
		end

		wait_idle();
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
